FILE: hdl/rapq_pkg.sv
// shared types, opcodes and control structs for the range add / point query tree
`timescale 1ns / 1ps

package rapq_pkg;

   // field widths of the request and response beats
   localparam int OP_W   = 2;
   localparam int POS_W  = 10;
   localparam int DATA_W = 32;

   // default number of leaf positions
   localparam int LEAVES_DEFAULT = 1024;

   // opcodes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic [POS_W-1:0]         left;
      logic [POS_W-1:0]         right;
      logic signed [DATA_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] point_value;
      logic                     found;
      logic [POS_W-1:0]         found_position;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clr_run;
      logic req_load;
      logic add_init;
      logic rd_lo;
      logic wr_lo;
      logic rd_hi;
      logic wr_hi;
      logic add_step;
      logic acc_clear;
      logic walk_left;
      logic walk_mid;
      logic walk_lo;
      logic walk_run;
      logic srch_init;
      logic srch_decide;
      logic rsp_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            clr_done;
      logic            add_empty;
      logic            add_more;
      logic            lo_odd;
      logic            hi_even;
      logic            query_oob;
      logic            srch_more;
      logic            walk_done;
      logic            rsp_free;
   } sts_type;

endpackage

FILE: hdl/rapq_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module rapq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rapq_ctrl.sv
// controller state machine: sequences clearing, range add, point walks and search
`timescale 1ns / 1ps

module rapq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rapq_pkg::sts_type sts,
   output rapq_pkg::cmd_type cmd
);

   import rapq_pkg::*;

   localparam logic [3:0] S_CLEAR       = 4'd0;
   localparam logic [3:0] S_IDLE        = 4'd1;
   localparam logic [3:0] S_DISPATCH    = 4'd2;
   localparam logic [3:0] S_ADD_LOOP    = 4'd3;
   localparam logic [3:0] S_ADD_LO_WR   = 4'd4;
   localparam logic [3:0] S_ADD_HI      = 4'd5;
   localparam logic [3:0] S_ADD_HI_WR   = 4'd6;
   localparam logic [3:0] S_WALK        = 4'd7;
   localparam logic [3:0] S_SRCH_STEP   = 4'd8;
   localparam logic [3:0] S_SRCH_DECIDE = 4'd9;
   localparam logic [3:0] S_DONE        = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       final_ff, final_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_run = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               final_in     = 1'b0;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.opcode)
               OP_ADD: begin
                  cmd.add_init = 1'b1;
                  state_in     = sts.add_empty ? S_DONE : S_ADD_LOOP;
               end
               OP_QUERY: begin
                  cmd.acc_clear = 1'b1;
                  if (sts.query_oob) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.walk_left = 1'b1;
                     state_in      = S_WALK;
                  end
               end
               OP_SEARCH: begin
                  cmd.srch_init = 1'b1;
                  state_in      = S_SRCH_STEP;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_ADD_LOOP: begin
            if (!sts.add_more) begin
               state_in = S_DONE;
            end else if (sts.lo_odd) begin
               cmd.rd_lo = 1'b1;
               state_in  = S_ADD_LO_WR;
            end else begin
               state_in = S_ADD_HI;
            end
         end
         S_ADD_LO_WR: begin
            cmd.wr_lo = 1'b1;
            state_in  = S_ADD_HI;
         end
         S_ADD_HI: begin
            if (sts.hi_even) begin
               cmd.rd_hi = 1'b1;
               state_in  = S_ADD_HI_WR;
            end else begin
               cmd.add_step = 1'b1;
               state_in     = S_ADD_LOOP;
            end
         end
         S_ADD_HI_WR: begin
            cmd.wr_hi    = 1'b1;
            cmd.add_step = 1'b1;
            state_in     = S_ADD_LOOP;
         end
         S_WALK: begin
            cmd.walk_run = 1'b1;
            if (sts.walk_done) begin
               if ((sts.opcode == OP_QUERY) || final_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SRCH_DECIDE;
               end
            end
         end
         S_SRCH_STEP: begin
            if (sts.srch_more) begin
               cmd.walk_mid = 1'b1;
            end else begin
               cmd.walk_lo = 1'b1;
               final_in    = 1'b1;
            end
            state_in = S_WALK;
         end
         S_SRCH_DECIDE: begin
            cmd.srch_decide = 1'b1;
            state_in        = S_SRCH_STEP;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

endmodule

FILE: hdl/rapq_dp.sv
// datapath: node store, add cover walk, point sum walk, search bounds and result beat
`timescale 1ns / 1ps

module rapq_dp #(
   parameter int LEAVES = rapq_pkg::LEAVES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  rapq_pkg::cmd_type cmd,
   output rapq_pkg::sts_type sts,
   input  rapq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rapq_pkg::rsp_type rsp_data
);

   import rapq_pkg::*;

   localparam int DEPTH  = 2 * LEAVES;
   localparam int NODE_W = $clog2(DEPTH);
   localparam int LAST   = LEAVES - 1;

   req_type             req_ff;
   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic [NODE_W:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic                pend_ff, pend_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic [POS_W-1:0]    slo_ff, slo_in, shi_ff, shi_in, mid_ff, mid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [POS_W-1:0]    lim_pos;
   logic [POS_W:0]      span;
   logic [POS_W-1:0]    mid_next;
   logic                meets;
   logic                wr_en, rd_en;
   logic [NODE_W-1:0]   wr_addr, rd_addr;
   logic [DATA_W-1:0]   wr_data, rd_data;

   // bound clamped to the last leaf, shared by add and search
   assign lim_pos  = (32'(req_ff.right) > LAST) ? POS_W'(LAST) : req_ff.right;
   assign span     = {1'b0, shi_ff} - {1'b0, slo_ff} + (POS_W+1)'(1);
   assign mid_next = slo_ff + span[POS_W:1];
   assign meets    = $signed(acc_ff) >= req_ff.amount;

   // node store port selection
   assign wr_en   = cmd.clr_run | cmd.wr_lo | cmd.wr_hi;
   assign wr_addr = cmd.clr_run ? clr_ff : (cmd.wr_lo ? lo_ff[NODE_W-1:0] : hi_ff[NODE_W-1:0]);
   assign wr_data = cmd.clr_run ? '0 : rd_data + req_ff.amount;
   assign rd_en   = cmd.rd_lo | cmd.rd_hi | (cmd.walk_run & (node_ff != '0));
   assign rd_addr = cmd.rd_lo ? lo_ff[NODE_W-1:0] : (cmd.rd_hi ? hi_ff[NODE_W-1:0] : node_ff);

   rapq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // status back to the controller
   always_comb begin
      sts           = '0;
      sts.opcode    = req_ff.opcode;
      sts.clr_done  = (clr_ff == NODE_W'(DEPTH - 1));
      sts.add_empty = (32'(req_ff.left) > 32'(lim_pos));
      sts.add_more  = (lo_ff <= hi_ff);
      sts.lo_odd    = lo_ff[0];
      sts.hi_even   = !hi_ff[0];
      sts.query_oob = (32'(req_ff.left) >= LEAVES);
      sts.srch_more = (slo_ff < shi_ff);
      sts.walk_done = (node_ff == '0) && !pend_ff;
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // clearing sweep address
   assign clr_in = cmd.clr_run ? clr_ff + NODE_W'(1) : clr_ff;

   // cover walk bounds for range add
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.add_init) begin
         lo_in = (NODE_W+1)'(req_ff.left) + (NODE_W+1)'(LEAVES);
         hi_in = (NODE_W+1)'(lim_pos) + (NODE_W+1)'(LEAVES);
      end else if (cmd.add_step) begin
         lo_in = (lo_ff + (NODE_W+1)'(1)) >> 1;
         hi_in = (hi_ff - (NODE_W+1)'(1)) >> 1;
      end
   end

   // leaf to root walk with one read in flight
   always_comb begin
      node_in = node_ff;
      pend_in = pend_ff;
      acc_in  = acc_ff;
      if (cmd.acc_clear || cmd.walk_left || cmd.walk_mid || cmd.walk_lo) begin
         acc_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.walk_left) begin
         node_in = NODE_W'(req_ff.left) + NODE_W'(LEAVES);
      end else if (cmd.walk_mid) begin
         node_in = NODE_W'(mid_next) + NODE_W'(LEAVES);
      end else if (cmd.walk_lo) begin
         node_in = NODE_W'(slo_ff) + NODE_W'(LEAVES);
      end else if (cmd.walk_run) begin
         pend_in = (node_ff != '0);
         node_in = node_ff >> 1;
         if (pend_ff) begin
            acc_in = acc_ff + rd_data;
         end
      end
   end

   // binary search bounds
   always_comb begin
      slo_in = slo_ff;
      shi_in = shi_ff;
      mid_in = mid_ff;
      if (cmd.srch_init) begin
         slo_in = '0;
         shi_in = lim_pos;
      end else if (cmd.walk_mid) begin
         mid_in = mid_next;
      end else if (cmd.srch_decide) begin
         if (meets) begin
            slo_in = mid_ff;
         end else begin
            shi_in = mid_ff - POS_W'(1);
         end
      end
   end

   // result beat register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_in       = '0;
         rsp_valid_in = 1'b1;
         if (req_ff.opcode == OP_QUERY) begin
            rsp_in.point_value = acc_ff;
         end else if ((req_ff.opcode == OP_SEARCH) && meets) begin
            rsp_in.found          = 1'b1;
            rsp_in.found_position = slo_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
      slo_ff <= slo_in;
      shi_ff <= shi_in;
      mid_ff <= mid_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/range_add_point_query_tree.sv
// Range add / point query segment tree, one beat in service at a time.
// Point query: one node read per cycle up the leaf path.
// Range add: read-modify-write of the cover nodes at each tree level, left end then right end.
// Search: up to log2(LEAVES) probe walks and a final check walk.
// All of these go through the registered-read node store, one node read per cycle.
// Reset: a clearing sweep zeroes all 2*LEAVES nodes of the node store; req_ready stays low until done.
`timescale 1ns / 1ps

module range_add_point_query_tree #(
   parameter int LEAVES = rapq_pkg::LEAVES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rapq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rapq_pkg::rsp_type rsp_data
);

   import rapq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   rapq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // node store and arithmetic
   rapq_dp #(
      .LEAVES(LEAVES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

FILE: dv/range_add_point_query_tree_tb.sv
// testbench for the range add / point query tree: directed edge cases, then random traffic
`timescale 1ns / 1ps

module range_add_point_query_tree_tb;
   import rapq_pkg::*;

   localparam int LEAVES = LEAVES_DEFAULT;
   // opcode that the block answers with an all-zero response
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predicted node store and the responses still owed by the block
   logic [DATA_W-1:0] node_sums [2*LEAVES];
   rsp_type           expected_rsps [$];
   int                error_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;

   range_add_point_query_tree #(.LEAVES(LEAVES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial forever #10 clock = ~clock;

   // value at one position: sum of the nodes from its leaf to the root
   function automatic logic [DATA_W-1:0] tree_point_sum(input int unsigned pos);
      logic [DATA_W-1:0] acc;
      int unsigned       node;
      acc = '0;
      if (pos >= LEAVES) return '0;
      for (node = pos + LEAVES; node != 0; node = node >> 1)
         acc += node_sums[node];
      return acc;
   endfunction

   // add to the cover nodes of lo..hi, right end clamped to the last leaf
   function automatic void tree_range_add(input int unsigned lo, input int unsigned hi,
                                          input logic [DATA_W-1:0] amt);
      if (hi >= LEAVES) hi = LEAVES - 1;
      if (lo > hi) return;
      lo += LEAVES;
      hi += LEAVES;
      while (lo <= hi) begin
         if (lo[0]) node_sums[lo] += amt;
         if (!hi[0]) node_sums[hi] += amt;
         lo = (lo + 1) >> 1;
         hi = (hi - 1) >> 1;
      end
   endfunction

   // binary search for the rightmost position in 0..bound at or above the threshold
   function automatic rsp_type tree_rightmost_search(input int unsigned bound,
                                                     input logic signed [DATA_W-1:0] thr);
      rsp_type     res;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      res = '0;
      lo  = 0;
      hi  = (bound >= LEAVES) ? LEAVES - 1 : bound;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if ($signed(tree_point_sum(mid)) >= thr) lo = mid;
         else hi = mid - 1;
      end
      if ($signed(tree_point_sum(lo)) >= thr) begin
         res.found          = 1'b1;
         res.found_position = lo[POS_W-1:0];
      end
      return res;
   endfunction

   // apply one accepted request to the predicted store and return its response
   function automatic rsp_type tree_apply(input req_type beat);
      rsp_type res;
      res = '0;
      case (beat.opcode)
         OP_ADD: tree_range_add(beat.left, beat.right, beat.amount);
         OP_QUERY: res.point_value = tree_point_sum(beat.left);
         OP_SEARCH: res = tree_rightmost_search(beat.right, beat.amount);
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic req_type make_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] l,
                                         input logic [POS_W-1:0] r, input logic [DATA_W-1:0] a);
      req_type beat;
      beat.opcode = op;
      beat.left   = l;
      beat.right  = r;
      beat.amount = a;
      return beat;
   endfunction

   // drive one request beat, wait for the handshake, then log the response it owes
   task automatic send_beat(input req_type beat);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      expected_rsps = {expected_rsps, tree_apply(beat)};
   endtask

   task automatic report_mismatch(input string field, input longint want, input longint got);
      error_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               error_count++;
               $error("response beat with none expected: %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.point_value !== want.point_value)
                  report_mismatch("point_value", want.point_value, rsp_data.point_value);
               if (rsp_data.found !== want.found)
                  report_mismatch("found", want.found, rsp_data.found);
               if (rsp_data.found_position !== want.found_position)
                  report_mismatch("found_position", want.found_position,
                                  rsp_data.found_position);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // freshly cleared store: everything reads zero
   task automatic test_cleared_store();
      send_beat(make_beat(OP_QUERY, 10'd777, 10'd0, 32'd0));
      send_beat(make_beat(OP_SEARCH, 10'd0, 10'd1023, 32'd1));
   endtask

   // full span, single leaves, empty ranges and a wrapping sum
   task automatic test_range_add_extremes();
      send_beat(make_beat(OP_ADD, 10'd0, 10'd1023, 32'h7fff_ffff));
      send_beat(make_beat(OP_ADD, 10'd1023, 10'd1023, 32'h8000_0000));
      send_beat(make_beat(OP_ADD, 10'd0, 10'd0, 32'hffff_ffff));
      send_beat(make_beat(OP_ADD, 10'd700, 10'd300, 32'd12345));
      send_beat(make_beat(OP_ADD, 10'd1023, 10'd0, 32'd5));
      send_beat(make_beat(OP_ADD, 10'd1, 10'd1022, 32'd1));
   endtask

   task automatic test_point_query_extremes();
      send_beat(make_beat(OP_QUERY, 10'd0, 10'd1023, 32'hffff_ffff));
      send_beat(make_beat(OP_QUERY, 10'd1, 10'd0, 32'd0));
      send_beat(make_beat(OP_QUERY, 10'd511, 10'd0, 32'd0));
      send_beat(make_beat(OP_QUERY, 10'd1022, 10'd0, 32'd0));
      send_beat(make_beat(OP_QUERY, 10'd1023, 10'd0, 32'd0));
   endtask

   // lowest and highest thresholds, a single-position bound, a not-found search
   task automatic test_search_cases();
      send_beat(make_beat(OP_SEARCH, 10'd0, 10'd1023, 32'h8000_0000));
      send_beat(make_beat(OP_SEARCH, 10'd1023, 10'd1023, 32'h7fff_ffff));
      send_beat(make_beat(OP_SEARCH, 10'd0, 10'd0, 32'h7fff_fffe));
      send_beat(make_beat(OP_SEARCH, 10'd0, 10'd1023, 32'd0));
      send_beat(make_beat(OP_SEARCH, 10'd0, 10'd512, 32'hffff_ffff));
   endtask

   task automatic test_unused_opcode();
      send_beat(make_beat(OP_UNUSED, 10'h3ff, 10'h3ff, 32'hffff_ffff));
      send_beat(make_beat(OP_UNUSED, 10'd0, 10'd0, 32'd0));
   endtask

   // mostly prefix adds so values stay non-increasing, with some disorder mixed in
   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      int          pick;
      int          sub;
      int unsigned pos;
      int          delta;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         sub  = $urandom_range(0, 99);
         if (pick < 35) begin
            if (sub < 70)
               send_beat(make_beat(OP_ADD, 10'd0, 10'($urandom_range(0, 1023)),
                                   32'($urandom_range(1, 1000))));
            else if (sub < 90)
               send_beat(make_beat(OP_ADD, 10'($urandom_range(0, 1023)),
                                   10'($urandom_range(0, 1023)),
                                   32'(int'($urandom_range(0, 2000)) - 1000)));
            else
               send_beat(make_beat(OP_ADD, 10'($urandom), 10'($urandom), $urandom));
         end else if (pick < 60) begin
            send_beat(make_beat(OP_QUERY, 10'($urandom), 10'($urandom), $urandom));
         end else if (pick < 95) begin
            if (sub < 70) begin
               // threshold close to a value actually held in the store
               pos   = $urandom_range(0, LEAVES - 1);
               delta = int'($urandom_range(0, 4)) - 2;
               send_beat(make_beat(OP_SEARCH, 10'($urandom), 10'($urandom_range(0, 1023)),
                                   tree_point_sum(pos) + 32'(delta)));
            end else begin
               send_beat(make_beat(OP_SEARCH, 10'($urandom), 10'($urandom), $urandom));
            end
         end else begin
            send_beat(make_beat(OP_UNUSED, 10'($urandom), 10'($urandom), $urandom));
         end
      end
   endtask

   initial begin
      foreach (node_sums[i]) node_sums[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 8;
      recv_stall_pct = 54;
      test_cleared_store();
      test_range_add_extremes();
      test_point_query_extremes();
      test_search_cases();
      test_unused_opcode();
      test_random_mix(400, 8, 54);
      test_random_mix(400, 54, 8);
      test_random_mix(400, 0, 0);
      req_valid <= 1'b0;

      // drain, then allow for a stray late beat
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
